// File: src/ltf_pkg.sv
// ============================================================================
// ltf_pkg
// Shared types, codes and reset values for the LED twinkle fade engine.
// ============================================================================
package ltf_pkg;

   localparam int LEDS_DEF = 64;   // default strip storage depth
   localparam int HUES     = 4;    // hue table entries in use (2..4)

   localparam int IDX_W  = 6;
   localparam int NUM_W  = 7;
   localparam int BYTE_W = 8;
   localparam int SEL_W  = 2;
   localparam int CSR_W  = 3;

   typedef enum logic [1:0] {
      ACT_TICK = 2'd0,
      ACT_ADD  = 2'd1,
      ACT_LOAD = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_RISE = 2'd1,
      PH_FALL = 2'd2,
      PH_BACK = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TICK,
      ST_UPD
   } state_type;

   // register indexes
   localparam logic [CSR_W-1:0] REG_NUM_LEDS      = 3'd0;
   localparam logic [CSR_W-1:0] REG_MAX_ACTIVE    = 3'd1;
   localparam logic [CSR_W-1:0] REG_NORMAL_BRIGHT = 3'd2;
   localparam logic [CSR_W-1:0] REG_HUE_ZERO      = 3'd3;
   localparam logic [CSR_W-1:0] REG_HUE_ONE       = 3'd4;
   localparam logic [CSR_W-1:0] REG_HUE_TWO       = 3'd5;
   localparam logic [CSR_W-1:0] REG_HUE_THREE     = 3'd6;

   // register reset values
   localparam logic [NUM_W-1:0]  NUM_LEDS_RST      = 7'd64;
   localparam logic [NUM_W-1:0]  MAX_ACTIVE_RST    = 7'd10;
   localparam logic [BYTE_W-1:0] NORMAL_BRIGHT_RST = 8'd80;
   localparam logic [BYTE_W-1:0] HUE_ZERO_RST      = 8'd96;
   localparam logic [BYTE_W-1:0] HUE_ONE_RST       = 8'd32;
   localparam logic [BYTE_W-1:0] HUE_TWO_RST       = 8'd160;
   localparam logic [BYTE_W-1:0] HUE_THREE_RST     = 8'd192;

   localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;

   typedef logic [3:0][BYTE_W-1:0] hue_tab_type;

   typedef struct packed {
      phase_type         phase;
      logic [SEL_W-1:0]  hue_sel;
      logic [BYTE_W-1:0] sat;
      logic [BYTE_W-1:0] val;
   } pixel_type;

   localparam pixel_type PIXEL_RST = '{phase: PH_IDLE, hue_sel: 2'd0,
                                       sat: 8'hFF, val: 8'h00};

   typedef struct packed {
      pixel_type pix;
      logic      went_idle;
   } step_type;

   // pick reduced into the hue table
   function automatic logic [SEL_W-1:0] pick_sel(input logic [SEL_W-1:0] pick);
      logic [SEL_W:0] wide;
      wide = {1'b0, pick};
      if (wide >= (SEL_W+1)'(HUES)) begin
         return SEL_W'(wide - (SEL_W+1)'(HUES));
      end
      return pick;
   endfunction

   // next table entry, wrapping
   function automatic logic [SEL_W-1:0] next_sel(input logic [SEL_W-1:0] sel);
      logic [SEL_W:0] wide;
      wide = {1'b0, sel} + (SEL_W+1)'(1);
      if (wide == (SEL_W+1)'(HUES)) begin
         return '0;
      end
      return SEL_W'(wide);
   endfunction

endpackage

// File: src/ltf_req_if.sv
// ============================================================================
// ltf_req_if
// Request channel: action, pixel index and hue pick with valid/ready.
// ============================================================================
interface ltf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [5:0] pixel_index;
   logic [1:0] hue_pick;

   modport source (output valid, action, pixel_index, hue_pick, input ready);
   modport sink   (input valid, action, pixel_index, hue_pick, output ready);
endinterface

// File: src/ltf_rsp_if.sv
// ============================================================================
// ltf_rsp_if
// Response channel: one HSV pixel per transaction with valid/ready.
// ============================================================================
interface ltf_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] out_index;
   logic [7:0] out_hue;
   logic [7:0] out_saturation;
   logic [7:0] out_value;
   logic       last;

   modport source (output valid, out_index, out_hue, out_saturation, out_value, last,
                   input ready);
   modport sink   (input valid, out_index, out_hue, out_saturation, out_value, last,
                   output ready);
endinterface

// File: src/ltf_pixel_step.sv
// ============================================================================
// ltf_pixel_step
// One animation step of a single pixel's fade phase.
// ============================================================================
module ltf_pixel_step (
   input  ltf_pkg::pixel_type              pix_in,
   input  ltf_pkg::hue_tab_type            hue_tab,
   input  logic [ltf_pkg::SEL_W-1:0]       pick,
   input  logic [ltf_pkg::BYTE_W-1:0]      normal_bright,
   output ltf_pkg::step_type               step_out
);

   logic [ltf_pkg::SEL_W-1:0]  sel;
   logic [ltf_pkg::BYTE_W:0]   val_inc;

   assign val_inc = {1'b0, pix_in.val} + 9'd1;

   // hue change: skip an entry that shows the same hue
   always_comb begin
      sel = ltf_pkg::pick_sel(pick);
      if (hue_tab[sel] == hue_tab[pix_in.hue_sel]) begin
         sel = ltf_pkg::next_sel(sel);
      end
   end

   always_comb begin
      step_out.pix       = pix_in;
      step_out.went_idle = 1'b0;
      case (pix_in.phase)
         ltf_pkg::PH_RISE: begin
            if (pix_in.val == 8'hFF && pix_in.sat == 8'h00) begin
               step_out.pix.phase = ltf_pkg::PH_FALL;
            end else begin
               step_out.pix.val = (pix_in.val >= 8'd254) ? 8'hFF : val_inc[7:0];
               step_out.pix.sat = (pix_in.sat <= 8'd2) ? 8'h00 : pix_in.sat - 8'd2;
            end
         end
         ltf_pkg::PH_FALL: begin
            if (pix_in.val == 8'h00 && pix_in.sat == 8'hFF) begin
               step_out.pix.hue_sel = sel;
               step_out.pix.phase   = ltf_pkg::PH_BACK;
            end else begin
               step_out.pix.val = (pix_in.val <= 8'd4) ? 8'h00 : pix_in.val - 8'd4;
               step_out.pix.sat = (pix_in.sat >= 8'd251) ? 8'hFF : pix_in.sat + 8'd4;
            end
         end
         ltf_pkg::PH_BACK: begin
            if (val_inc >= {1'b0, normal_bright}) begin
               step_out.pix.val   = normal_bright;
               step_out.pix.phase = ltf_pkg::PH_IDLE;
               step_out.went_idle = 1'b1;
            end else begin
               step_out.pix.val = val_inc[7:0];
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// File: src/led_twinkle_fade_engine_core.sv
// ============================================================================
// led_twinkle_fade_engine_core
// HSV pixel strip with per-pixel three-phase twinkle fade, kept in one RAM.
// ============================================================================
//
//  channel   | dir | handshake     | content
//  ----------+-----+---------------+------------------------------------------
//  req_bus   | in  | valid/ready   | action, pixel_index, hue_pick
//  rsp_bus   | out | valid/ready   | out_index, out_hue, out_saturation,
//            |     |               | out_value, last (one pixel each)
//  csr_*     | in  | write enable  | csr_index selects register, csr_wdata
//
//  Add and load: RAM read, then modify and write back.
//  Tick: walks every RAM entry; one entry is read, stepped and written back
//  each cycle unless the response stalls the walk, and emitted only inside the strip.
//  A stalled response holds the walk at the current pixel; the next request
//  is taken once the walk is done, even while the last pixel still waits.
//  Synchronous reset; per-entry valid bits stand in for the RAM reset value.
//
module led_twinkle_fade_engine_core #(
   parameter int LEDS = ltf_pkg::LEDS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   ltf_req_if.sink                     req_bus,
   ltf_rsp_if.source                   rsp_bus,
   input  logic                        csr_we,
   input  logic [ltf_pkg::CSR_W-1:0]   csr_index,
   input  logic [ltf_pkg::BYTE_W-1:0]  csr_wdata
);

   localparam int IW = (LEDS > 1) ? $clog2(LEDS) : 1;

   // ---------------- configuration registers ----------------
   logic [ltf_pkg::NUM_W-1:0]  num_leds_ff;
   logic [ltf_pkg::NUM_W-1:0]  max_active_ff;
   logic [ltf_pkg::BYTE_W-1:0] normal_bright_ff;
   ltf_pkg::hue_tab_type       hue_tab_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_leds_ff      <= ltf_pkg::NUM_LEDS_RST;
         max_active_ff    <= ltf_pkg::MAX_ACTIVE_RST;
         normal_bright_ff <= ltf_pkg::NORMAL_BRIGHT_RST;
         hue_tab_ff[0]    <= ltf_pkg::HUE_ZERO_RST;
         hue_tab_ff[1]    <= ltf_pkg::HUE_ONE_RST;
         hue_tab_ff[2]    <= ltf_pkg::HUE_TWO_RST;
         hue_tab_ff[3]    <= ltf_pkg::HUE_THREE_RST;
      end else if (csr_we) begin
         case (csr_index)
            ltf_pkg::REG_NUM_LEDS:      num_leds_ff      <= csr_wdata[ltf_pkg::NUM_W-1:0];
            ltf_pkg::REG_MAX_ACTIVE:    max_active_ff    <= csr_wdata[ltf_pkg::NUM_W-1:0];
            ltf_pkg::REG_NORMAL_BRIGHT: normal_bright_ff <= csr_wdata;
            ltf_pkg::REG_HUE_ZERO:      hue_tab_ff[0]    <= csr_wdata;
            ltf_pkg::REG_HUE_ONE:       hue_tab_ff[1]    <= csr_wdata;
            ltf_pkg::REG_HUE_TWO:       hue_tab_ff[2]    <= csr_wdata;
            ltf_pkg::REG_HUE_THREE:     hue_tab_ff[3]    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // strip length clamped into 1..LEDS
   logic [ltf_pkg::NUM_W-1:0] strip_n;
   assign strip_n = (num_leds_ff == '0) ? 7'd1 :
                    (num_leds_ff > 7'(LEDS)) ? 7'(LEDS) : num_leds_ff;

   // ---------------- pixel RAM ----------------
   ltf_pkg::pixel_type pix_mem [LEDS];
   logic [LEDS-1:0]    vld_ff;
   ltf_pkg::pixel_type rd_data_ff;
   logic               rd_vld_ff;

   logic               rd_en;
   logic [IW-1:0]      rd_addr;
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   ltf_pkg::pixel_type wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pix_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= pix_mem[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
   end

   // an entry never written reads as the reset pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   ltf_pkg::pixel_type cur_pix;
   assign cur_pix = rd_vld_ff ? rd_data_ff : ltf_pkg::PIXEL_RST;

   // ---------------- control ----------------
   ltf_pkg::state_type              state_ff, state_in;
   logic [IW-1:0]                   cnt_ff, cnt_in;
   ltf_pkg::action_type             act_ff, act_in;
   logic [ltf_pkg::IDX_W-1:0]       idx_ff, idx_in;
   logic [ltf_pkg::SEL_W-1:0]       pick_ff, pick_in;
   logic [ltf_pkg::NUM_W-1:0]       active_ff, active_in;

   logic                            rsp_valid_ff;
   logic [ltf_pkg::IDX_W-1:0]       rsp_index_ff;
   logic [ltf_pkg::BYTE_W-1:0]      rsp_hue_ff;
   logic [ltf_pkg::BYTE_W-1:0]      rsp_sat_ff;
   logic [ltf_pkg::BYTE_W-1:0]      rsp_val_ff;
   logic                            rsp_last_ff;
   logic                            rsp_load;

   ltf_pkg::step_type               step;
   ltf_pkg::action_type             req_act;
   logic                            emit;
   logic                            go;
   logic                            in_range;
   logic                            req_ready;

   ltf_pixel_step u_step (
      .pix_in        (cur_pix),
      .hue_tab       (hue_tab_ff),
      .pick          (pick_ff),
      .normal_bright (normal_bright_ff),
      .step_out      (step)
   );

   assign req_act  = ltf_pkg::action_type'(req_bus.action);
   assign emit     = (7'(cnt_ff) < strip_n);
   // the walk moves on unless this pixel must be shown and the slot is busy
   assign go       = !emit || !rsp_valid_ff || rsp_bus.ready;
   assign in_range = ({1'b0, idx_ff} < strip_n);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ltf_pkg::ST_IDLE;
         active_ff <= '0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      act_ff  <= act_in;
      idx_ff  <= idx_in;
      pick_ff <= pick_in;
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      act_in    = act_ff;
      idx_in    = idx_ff;
      pick_in   = pick_ff;
      active_in = active_ff;
      rd_en     = 1'b0;
      rd_addr   = cnt_ff;
      wr_en     = 1'b0;
      wr_addr   = cnt_ff;
      wr_data   = step.pix;
      rsp_load  = 1'b0;
      req_ready = 1'b0;
      case (state_ff)
         ltf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_bus.valid) begin
               act_in  = req_act;
               idx_in  = req_bus.pixel_index;
               pick_in = req_bus.hue_pick;
               case (req_act)
                  ltf_pkg::ACT_TICK: begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     cnt_in   = '0;
                     state_in = ltf_pkg::ST_TICK;
                  end
                  ltf_pkg::ACT_ADD, ltf_pkg::ACT_LOAD: begin
                     rd_en    = 1'b1;
                     rd_addr  = req_bus.pixel_index[IW-1:0];
                     state_in = ltf_pkg::ST_UPD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ltf_pkg::ST_TICK: begin
            // step pixel cnt_ff, write back, emit; prefetch the next one
            if (go) begin
               wr_en    = 1'b1;
               rsp_load = emit;
               if (step.went_idle && active_ff != '0) begin
                  active_in = active_ff - 7'd1;
               end
               if (cnt_ff == IW'(LEDS - 1)) begin
                  state_in = ltf_pkg::ST_IDLE;
               end else begin
                  cnt_in  = cnt_ff + IW'(1);
                  rd_en   = 1'b1;
                  rd_addr = cnt_ff + IW'(1);
               end
            end
         end
         ltf_pkg::ST_UPD: begin
            wr_addr  = idx_ff[IW-1:0];
            state_in = ltf_pkg::ST_IDLE;
            if (in_range) begin
               if (act_ff == ltf_pkg::ACT_ADD) begin
                  if (cur_pix.phase == ltf_pkg::PH_IDLE && active_ff < max_active_ff) begin
                     wr_en         = 1'b1;
                     wr_data       = cur_pix;
                     wr_data.phase = ltf_pkg::PH_RISE;
                     active_in     = active_ff + 7'd1;
                  end
               end else begin
                  // load keeps the fade phase
                  wr_en           = 1'b1;
                  wr_data.phase   = cur_pix.phase;
                  wr_data.hue_sel = ltf_pkg::pick_sel(pick_ff);
                  wr_data.sat     = ltf_pkg::BYTE_MAX;
                  wr_data.val     = normal_bright_ff;
               end
            end
         end
         default: begin
            state_in = ltf_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_index_ff <= ltf_pkg::IDX_W'(cnt_ff);
         rsp_hue_ff   <= hue_tab_ff[step.pix.hue_sel];
         rsp_sat_ff   <= step.pix.sat;
         rsp_val_ff   <= step.pix.val;
         rsp_last_ff  <= ((7'(cnt_ff) + 7'd1) == strip_n);
      end
   end

   assign req_bus.ready          = req_ready;
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.out_index      = rsp_index_ff;
   assign rsp_bus.out_hue        = rsp_hue_ff;
   assign rsp_bus.out_saturation = rsp_sat_ff;
   assign rsp_bus.out_value      = rsp_val_ff;
   assign rsp_bus.last           = rsp_last_ff;

endmodule

// File: src/ltf_checker.sv
// ============================================================================
// ltf_checker
// Port-level checks on the twinkle fade engine, bound to the top level.
// ============================================================================
module ltf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_action,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [5:0] rsp_out_index,
   input logic       rsp_last
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_index) && $stable(rsp_last))
      else $error("response changed while stalled");

   // reset empties the response slot
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a strip walk in flight blocks new requests
   a_mid_strip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken during strip output");

   // a tick starts a walk
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == ltf_pkg::ACT_TICK |=> !req_ready)
      else $error("tick did not start a strip walk");

endmodule

bind led_twinkle_fade_engine_core ltf_checker u_ltf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .req_action    (req_bus.action),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_out_index (rsp_bus.out_index),
   .rsp_last      (rsp_bus.last)
);

// File: dv/ltf_fade_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ============================================================================
// ltf_fade_scoreboard_pkg
// Pixel strip predictor and in-order checker for the twinkle fade engine.
// ============================================================================
package ltf_fade_scoreboard_pkg;
   import ltf_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0]  index;
      logic [BYTE_W-1:0] hue;
      logic [BYTE_W-1:0] sat;
      logic [BYTE_W-1:0] val;
      logic              last;
   } hsv_pixel_type;

   class fade_scoreboard;
      logic [SEL_W-1:0]  hue_sel [LEDS_DEF];
      logic [BYTE_W-1:0] sat     [LEDS_DEF];
      logic [BYTE_W-1:0] val     [LEDS_DEF];
      phase_type         phase   [LEDS_DEF];
      int unsigned       active_count;
      logic [NUM_W-1:0]  num_leds;
      logic [NUM_W-1:0]  max_active;
      logic [BYTE_W-1:0] normal_bright;
      logic [BYTE_W-1:0] hue_tab [HUES];
      hsv_pixel_type     strip_due[$];
      int                mismatches;

      function new();
         num_leds      = NUM_LEDS_RST;
         max_active    = MAX_ACTIVE_RST;
         normal_bright = NORMAL_BRIGHT_RST;
         hue_tab[0]    = HUE_ZERO_RST;
         hue_tab[1]    = HUE_ONE_RST;
         hue_tab[2]    = HUE_TWO_RST;
         hue_tab[3]    = HUE_THREE_RST;
         for (int i = 0; i < LEDS_DEF; i++) begin
            hue_sel[i] = '0;
            sat[i]     = BYTE_MAX;
            val[i]     = '0;
            phase[i]   = PH_IDLE;
         end
         active_count = 0;
         mismatches   = 0;
      endfunction

      function void write_reg(logic [CSR_W-1:0] index, logic [BYTE_W-1:0] data);
         case (index)
            REG_NUM_LEDS:      num_leds      = data[NUM_W-1:0];
            REG_MAX_ACTIVE:    max_active    = data[NUM_W-1:0];
            REG_NORMAL_BRIGHT: normal_bright = data;
            REG_HUE_ZERO:      hue_tab[0]    = data;
            REG_HUE_ONE:       hue_tab[1]    = data;
            REG_HUE_TWO:       hue_tab[2]    = data;
            REG_HUE_THREE:     hue_tab[3]    = data;
            default: ;
         endcase
      endfunction

      function int unsigned strip_len();
         if (num_leds == 0) return 1;
         if (num_leds > LEDS_DEF) return LEDS_DEF;
         return num_leds;
      endfunction

      function int unsigned outstanding();
         return strip_due.size();
      endfunction

      // one animation step of one pixel
      function void advance_pixel(int i, logic [SEL_W-1:0] pick);
         int unsigned      v;
         int unsigned      s;
         logic [SEL_W-1:0] sel;
         v = val[i];
         s = sat[i];
         case (phase[i])
            PH_RISE: begin
               if (v == 255 && s == 0) begin
                  phase[i] = PH_FALL;
               end else begin
                  v = (v + 1 >= 255) ? 255 : v + 1;
                  s = (s <= 2) ? 0 : s - 2;
               end
            end
            PH_FALL: begin
               if (v == 0 && s == 255) begin
                  sel = SEL_W'(int'(pick) % HUES);
                  // same color as now: take the next table entry
                  if (hue_tab[sel] == hue_tab[hue_sel[i]]) begin
                     sel = SEL_W'((int'(sel) + 1) % HUES);
                  end
                  hue_sel[i] = sel;
                  phase[i]   = PH_BACK;
               end else begin
                  v = (v <= 4) ? 0 : v - 4;
                  s = (s + 4 >= 255) ? 255 : s + 4;
               end
            end
            PH_BACK: begin
               if (v + 1 >= normal_bright) begin
                  v        = normal_bright;
                  phase[i] = PH_IDLE;
                  if (active_count > 0) active_count--;
               end else begin
                  v = v + 1;
               end
            end
            default: ;
         endcase
         val[i] = BYTE_W'(v);
         sat[i] = BYTE_W'(s);
      endfunction

      function void note_request(action_type act, logic [IDX_W-1:0] idx,
                                 logic [SEL_W-1:0] pick);
         int unsigned   n;
         hsv_pixel_type px;
         n = strip_len();
         case (act)
            ACT_ADD: begin
               if (idx < n && phase[idx] == PH_IDLE && active_count < max_active) begin
                  phase[idx] = PH_RISE;
                  active_count++;
               end
            end
            ACT_LOAD: begin
               if (idx < n) begin
                  hue_sel[idx] = SEL_W'(int'(pick) % HUES);
                  sat[idx]     = BYTE_MAX;
                  val[idx]     = normal_bright;
               end
            end
            ACT_TICK: begin
               // pixels past the strip end still step, but are not emitted
               for (int i = 0; i < LEDS_DEF; i++) advance_pixel(i, pick);
               for (int i = 0; i < n; i++) begin
                  px.index  = IDX_W'(i);
                  px.hue    = hue_tab[hue_sel[i]];
                  px.sat    = sat[i];
                  px.val    = val[i];
                  px.last   = (i + 1 == n);
                  strip_due = {strip_due, px};
               end
            end
            default: ;
         endcase
      endfunction

      function void check_pixel(hsv_pixel_type got);
         hsv_pixel_type want;
         if (strip_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: unexpected pixel idx %0d hue %0d sat %0d val %0d last %0d",
                        $realtime, got.index, got.hue, got.sat, got.val, got.last);
            end
            return;
         end
         want = strip_due.pop_front();
         if (got.index !== want.index || got.hue !== want.hue || got.sat !== want.sat ||
             got.val !== want.val || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: pixel exp idx %0d hue %0d sat %0d val %0d last %0d",
                        $realtime, want.index, want.hue, want.sat, want.val, want.last);
               $display("%0t: pixel got idx %0d hue %0d sat %0d val %0d last %0d",
                        $realtime, got.index, got.hue, got.sat, got.val, got.last);
            end
         end
      endfunction
   endclass

endpackage

// File: dv/led_twinkle_fade_engine_core_test.sv
`timescale 1ns / 100ps
// ============================================================================
// led_twinkle_fade_engine_core_test
// Drives add, load and tick transactions into the fade engine, predicts every
// emitted HSV pixel and checks the response stream in order. Runs directed
// corner cases, full fade lifecycles and random traffic under several
// register settings and sender/receiver idling mixes.
// ============================================================================
module led_twinkle_fade_engine_core_test;
   import ltf_pkg::*;
   import ltf_fade_scoreboard_pkg::*;

   // settle covers a full tick walk plus margin
   localparam int SETTLE_CYCLES  = 100;
   // quiet cycles allowed: settle, register writes and long stall runs
   localparam int WATCHDOG_LIMIT = 3000;
   // ticks from a load at full brightness through the rise to the first fall step
   localparam int RISE_TICKS     = 130;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [CSR_W-1:0]  csr_index;
   logic [BYTE_W-1:0] csr_wdata;

   ltf_req_if req_bus();
   ltf_rsp_if rsp_bus();

   int send_idle_pct;
   int rsp_stall_pct;
   int quiet_cycles;

   fade_scoreboard sb;

   led_twinkle_fade_engine_core #(.LEDS(LEDS_DEF)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus.sink),
      .rsp_bus   (rsp_bus.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // receiver: random back-pressure at the current stall rate
   always @(posedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(99) >= rsp_stall_pct);
   end

   // monitor: sample both channels at the edge, before any driven update lands
   always @(posedge clock) begin : monitor
      hsv_pixel_type got;
      bit            took;
      if (!reset) begin
         took = 1'b0;
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.index = rsp_bus.out_index;
            got.hue   = rsp_bus.out_hue;
            got.sat   = rsp_bus.out_saturation;
            got.val   = rsp_bus.out_value;
            got.last  = rsp_bus.last;
            sb.check_pixel(got);
            took = 1'b1;
         end
         if (req_bus.valid && req_bus.ready) begin
            sb.note_request(action_type'(req_bus.action), req_bus.pixel_index,
                            req_bus.hue_pick);
            took = 1'b1;
         end
         quiet_cycles = took ? 0 : quiet_cycles + 1;
         // watchdog: nothing moving on either channel for too long
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // one request transaction; valid stays high afterward so back-to-back
   // transactions do not drop it within the same step
   task automatic send_req(action_type act, logic [IDX_W-1:0] idx, logic [SEL_W-1:0] pick);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.action      <= act;
      req_bus.pixel_index <= idx;
      req_bus.hue_pick    <= pick;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
   endtask

   // drain all expected pixels, then let a trailing walk finish
   task automatic hold_until_idle();
      req_bus.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(logic [CSR_W-1:0] index, int unsigned data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= BYTE_W'(data);
      sb.write_reg(index, BYTE_W'(data));
      @(posedge clock);
   endtask

   // full register set, only with the engine idle
   task automatic write_config(int unsigned leds, int unsigned most, int unsigned bright,
                               int unsigned h0, int unsigned h1, int unsigned h2,
                               int unsigned h3);
      hold_until_idle();
      put_reg(REG_NUM_LEDS, leds);
      put_reg(REG_MAX_ACTIVE, most);
      put_reg(REG_NORMAL_BRIGHT, bright);
      put_reg(REG_HUE_ZERO, h0);
      put_reg(REG_HUE_ONE, h1);
      put_reg(REG_HUE_TWO, h2);
      put_reg(REG_HUE_THREE, h3);
      csr_we <= 1'b0;
   endtask

   // random settings, extremes included; hues repeat often so the
   // same-color skip gets exercised
   task automatic random_config();
      int unsigned leds;
      int unsigned most;
      int unsigned bright;
      int unsigned h0, h1, h2, h3;
      case ($urandom_range(9))
         0:       leds = 0;
         1:       leds = 127;
         2:       leds = LEDS_DEF;
         3:       leds = $urandom_range(127);
         default: leds = $urandom_range(1, 12);
      endcase
      case ($urandom_range(3))
         0:       most = 0;
         1:       most = 127;
         default: most = $urandom_range(1, 12);
      endcase
      case ($urandom_range(3))
         0:       bright = 0;
         1:       bright = 255;
         default: bright = $urandom_range(255);
      endcase
      h0 = $urandom_range(255);
      h1 = ($urandom_range(2) == 0) ? h0 : $urandom_range(255);
      h2 = ($urandom_range(2) == 0) ? h1 : $urandom_range(255);
      h3 = ($urandom_range(2) == 0) ? h2 : $urandom_range(255);
      write_config(leds, most, bright, h0, h1, h2, h3);
   endtask

   // random mix; indexes mostly near the strip, just past its end included
   task automatic random_item();
      int unsigned roll;
      int unsigned lim;
      action_type  act;
      logic [IDX_W-1:0] idx;
      roll = $urandom_range(99);
      if (roll < 50)      act = ACT_TICK;
      else if (roll < 75) act = ACT_ADD;
      else if (roll < 90) act = ACT_LOAD;
      else                act = ACT_NONE;
      lim = (sb.strip_len() > 63) ? 63 : sb.strip_len();
      if ($urandom_range(3) == 0) idx = IDX_W'($urandom_range(63));
      else                        idx = IDX_W'($urandom_range(lim));
      send_req(act, idx, SEL_W'($urandom_range(3)));
   endtask

   initial begin
      sb                  = new();
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = REG_NUM_LEDS;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.action      = ACT_TICK;
      req_bus.pixel_index = '0;
      req_bus.hue_pick    = '0;
      rsp_bus.ready       = 1'b0;
      send_idle_pct       = 0;
      rsp_stall_pct       = 0;
      quiet_cycles        = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // ---- directed, reset settings ----
      send_req(ACT_LOAD, 0, 0);
      send_req(ACT_LOAD, 63, 3);
      send_req(ACT_LOAD, 7, 2);
      send_req(ACT_ADD, 0, 0);
      send_req(ACT_ADD, 0, 1);        // already fading: ignored
      send_req(ACT_ADD, 63, 0);
      send_req(ACT_ADD, 7, 0);
      send_req(ACT_NONE, 9, 1);       // unused code: no effect, no pixels
      send_req(ACT_TICK, 0, 0);
      send_req(ACT_TICK, 0, 3);
      send_req(ACT_LOAD, 0, 1);       // load over a fading pixel
      send_req(ACT_TICK, 5, 2);

      // ---- low extremes: strip clamps to one pixel, no new fades ----
      write_config(0, 0, 0, 0, 0, 0, 0);
      send_req(ACT_ADD, 0, 0);        // active limit reached: ignored
      send_req(ACT_LOAD, 1, 3);       // past strip end: ignored
      send_req(ACT_LOAD, 0, 2);
      send_req(ACT_TICK, 0, 1);       // pixels past the end keep stepping

      // ---- high extremes: strip clamps to full depth ----
      write_config(127, 127, 255, 255, 255, 0, 255);
      send_req(ACT_ADD, 5, 0);
      send_req(ACT_ADD, 63, 0);
      send_req(ACT_TICK, 0, 3);
      send_req(ACT_TICK, 0, 0);

      // ---- full lifecycles: rise to white, fall, recolor, return ----
      // loading at full brightness starts the rise at white value, so only
      // saturation drains; a load at zero brightness then drops the falling
      // pixels straight to black, and a low resting brightness ends the return
      write_config(4, 127, 255, 96, 96, 160, 192);
      for (int i = 0; i < 4; i++) send_req(ACT_LOAD, IDX_W'(i), SEL_W'($urandom_range(3)));
      for (int i = 0; i < 4; i++) send_req(ACT_ADD, IDX_W'(i), 0);
      // idling mix changes every quarter of the rise
      for (int k = 0; k < RISE_TICKS; k++) begin
         case (k / 33)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 64; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 64; end
            default: begin send_idle_pct = 18; rsp_stall_pct = 18; end
         endcase
         send_req(ACT_TICK, IDX_W'($urandom_range(63)), SEL_W'($urandom_range(3)));
      end
      write_config(4, 127, 0, 96, 96, 160, 192);
      for (int i = 0; i < 4; i++) send_req(ACT_LOAD, IDX_W'(i), SEL_W'($urandom_range(3)));
      // picks 0 and 1 both show the first hue, so the skip is hit often
      send_req(ACT_TICK, 0, SEL_W'($urandom_range(1)));
      write_config(4, 127, 2, 96, 96, 160, 192);
      repeat (2) send_req(ACT_TICK, 0, SEL_W'($urandom_range(3)));

      // ---- random traffic, new settings and idling mix per stretch ----
      for (int p = 0; p < 4; p++) begin
         random_config();
         case (p)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 64; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 64; end
            default: begin send_idle_pct = 18; rsp_stall_pct = 18; end
         endcase
         repeat (4) random_item();
      end

      // ---- wind down ----
      hold_until_idle();
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: sim.f
src/ltf_pkg.sv
src/ltf_req_if.sv
src/ltf_rsp_if.sv
src/ltf_pixel_step.sv
src/led_twinkle_fade_engine_core.sv
src/ltf_checker.sv
dv/ltf_fade_scoreboard_pkg.sv
dv/led_twinkle_fade_engine_core_test.sv
